### rtl/ted_pkg.sv
// ----------------------------------------------------------------------------
// ted_pkg: shared types and constants for the touch event decoder
// Beat payload structs, report kind codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ted_pkg;

	localparam int unsigned CoordW  = 12;
	localparam int unsigned SizeW   = 16;
	localparam int unsigned ValueW  = 27;
	localparam int unsigned CfgIdxW = 8;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [7:0] x_high;
		logic [7:0] y_high;
		logic [7:0] xy_low;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]        report_kind;
		logic [ValueW-1:0] report_value;
		logic              last_report;
	} out_beat_t;

	localparam logic [1:0] KIND_ABS_X  = 2'd0;
	localparam logic [1:0] KIND_ABS_Y  = 2'd1;
	localparam logic [1:0] KIND_BUTTON = 2'd2;
	localparam logic [1:0] KIND_SYNC   = 2'd3;

	localparam logic [CfgIdxW-1:0] CFG_PANEL_WIDTH  = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_PANEL_HEIGHT = 8'd1;

	localparam logic [1:0] TSTATE_NONE    = 2'd0;
	localparam logic [1:0] TSTATE_PRESS   = 2'd1;
	localparam logic [1:0] TSTATE_MOVE    = 2'd2;
	localparam logic [1:0] TSTATE_RELEASE = 2'd3;

	localparam logic [3:0] TOUCH_ID_MAIN  = 4'd1;
	localparam logic [1:0] TYPE_COORD     = 2'd0;

endpackage

`default_nettype wire

### rtl/ted_divider.sv
// ----------------------------------------------------------------------------
// ted_divider: restoring radix-2 divider
// Unsigned 27-bit by 16-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ted_divider
	import ted_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ValueW-1:0] dividend,
	input  wire logic [SizeW-1:0]  divisor,
	output logic                   done,
	output logic [ValueW-1:0]      quotient
);

	localparam int unsigned CntW = $clog2(ValueW);
	localparam logic [CntW-1:0] LastStep = CntW'(ValueW - 1);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [SizeW-1:0]  rem_q;
	logic [ValueW-1:0] quo_q;
	logic [SizeW-1:0]  dsr_q;

	logic [SizeW:0]    rem_shift;
	logic [SizeW+1:0]  diff;

	assign rem_shift = {rem_q, quo_q[ValueW-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// keep the difference only when it did not borrow
			if (!diff[SizeW+1]) begin
				rem_q <= diff[SizeW-1:0];
				quo_q <= {quo_q[ValueW-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[SizeW-1:0];
				quo_q <= {quo_q[ValueW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### rtl/touch_event_decoder_core.sv
// ----------------------------------------------------------------------------
// touch_event_decoder_core: touch controller event to pointer report decoder
// Takes one four-byte coordinate event per input beat and emits abs X, abs Y,
// button and sync report beats. Press and move events scale each raw 12-bit
// coordinate by 32767 / panel size through one shared restoring divider, one
// quotient bit per cycle, X first then Y. Such an event emits its report beats,
// with or without a button beat, after these steps: a start, the X division, a
// done handoff, a start, the Y division and a done handoff; each beat is then
// registered on the output. The input is ready again in the cycle that presents
// the last report beat, so the next event can be taken then, later if the sink
// stalls. Release events take two beats; ignored events are simply dropped.
// The input is not ready while an event is being worked on. A panel size of
// zero divides by one. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_event_decoder_core
	import ted_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_beat_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_beat_t               out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [SizeW-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	localparam logic [SizeW-1:0] WidthReset  = 16'd1080;
	localparam logic [SizeW-1:0] HeightReset = 16'd2520;

	state_t            state_q;
	logic [SizeW-1:0]  width_q;
	logic [SizeW-1:0]  height_q;
	logic              finger_q;
	logic              rel_q;
	logic              btn_q;
	logic              sel_y_q;
	logic              start_q;
	logic [1:0]        step_q;
	logic [CoordW-1:0] raw_x_q;
	logic [CoordW-1:0] raw_y_q;
	logic [ValueW-1:0] qx_q;
	logic [ValueW-1:0] qy_q;
	logic              out_valid_q;
	out_beat_t         out_q;

	logic              accept;
	logic [1:0]        tstate;
	logic              relevant;
	logic              is_pos;
	logic              is_rel;
	logic [CoordW-1:0] raw_sel;
	logic [SizeW-1:0]  size_sel;
	logic [ValueW-1:0] dividend;
	logic [SizeW-1:0]  divisor;
	logic              div_done;
	logic [ValueW-1:0] quotient;
	out_beat_t         beat;
	logic              load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	assign tstate   = in_data.status_byte[7:6];
	assign relevant = (in_data.status_byte[1:0] == TYPE_COORD) &&
		(in_data.status_byte[5:2] == TOUCH_ID_MAIN);
	assign is_pos   = relevant && (tstate == TSTATE_PRESS || tstate == TSTATE_MOVE);
	assign is_rel   = relevant && (tstate == TSTATE_RELEASE) && finger_q;

	// raw * 32767 as (raw << 15) - raw
	assign raw_sel  = sel_y_q ? raw_y_q : raw_x_q;
	assign size_sel = sel_y_q ? height_q : width_q;
	assign dividend = {raw_sel, 15'd0} - {15'd0, raw_sel};
	assign divisor  = (size_sel == '0) ? SizeW'(1) : size_sel;

	ted_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		beat = '0;
		if (rel_q) begin
			if (step_q == 2'd0) begin
				beat.report_kind = KIND_BUTTON;
			end else begin
				beat.report_kind = KIND_SYNC;
				beat.last_report = 1'b1;
			end
		end else begin
			case (step_q)
				2'd0: begin
					beat.report_kind  = KIND_ABS_X;
					beat.report_value = qx_q;
				end
				2'd1: begin
					beat.report_kind  = KIND_ABS_Y;
					beat.report_value = qy_q;
				end
				2'd2: begin
					if (btn_q) begin
						beat.report_kind  = KIND_BUTTON;
						beat.report_value = ValueW'(1);
					end else begin
						beat.report_kind = KIND_SYNC;
						beat.last_report = 1'b1;
					end
				end
				default: begin
					beat.report_kind = KIND_SYNC;
					beat.last_report = 1'b1;
				end
			endcase
		end
	end

	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= WidthReset;
			height_q    <= HeightReset;
			finger_q    <= 1'b0;
			rel_q       <= 1'b0;
			btn_q       <= 1'b0;
			sel_y_q     <= 1'b0;
			start_q     <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PANEL_WIDTH) begin
					width_q <= cfg_data;
				end else if (cfg_index == CFG_PANEL_HEIGHT) begin
					height_q <= cfg_data;
				end
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (is_rel) begin
							rel_q    <= 1'b1;
							finger_q <= 1'b0;
							state_q  <= ST_EMIT;
						end else if (is_pos) begin
							rel_q    <= 1'b0;
							btn_q    <= !finger_q;
							finger_q <= 1'b1;
							sel_y_q  <= 1'b0;
							start_q  <= 1'b1;
							state_q  <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (!sel_y_q) begin
							// X done, rerun the divider on Y
							sel_y_q <= 1'b1;
							start_q <= 1'b1;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						step_q      <= step_q + 1'b1;
						if (beat.last_report) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_x_q <= {in_data.x_high, in_data.xy_low[7:4]};
			raw_y_q <= {in_data.y_high, in_data.xy_low[3:0]};
		end
		if (div_done) begin
			if (sel_y_q) begin
				qy_q <= quotient;
			end else begin
				qx_q <= quotient;
			end
		end
		if (load_out) begin
			out_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
